@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ble_pkg.sv @@
// ----------------------------------------------------------------------------
// ble_pkg
// Types, widths and constants of the battery level estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ble_pkg;

   // Ring depths and derived widths
   localparam int OPEN_DEPTH   = 32;
   localparam int LOADED_DEPTH = 32;
   localparam int RING_MAX     = (OPEN_DEPTH > LOADED_DEPTH) ? OPEN_DEPTH : LOADED_DEPTH;

   localparam int ADC_W    = 12;
   localparam int VREF_W   = 13;
   localparam int EXT_W    = 16;
   localparam int MV_W     = 13;
   localparam int OUT_MV_W = 16;
   localparam int PROD_W   = ADC_W + VREF_W;
   localparam int STEP_W   = $clog2(MV_W + 1);

   localparam int OPEN_CNT_W   = $clog2(OPEN_DEPTH + 1);
   localparam int LOADED_CNT_W = $clog2(LOADED_DEPTH + 1);
   localparam int OPEN_PTR_W   = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
   localparam int LOADED_PTR_W = (LOADED_DEPTH > 1) ? $clog2(LOADED_DEPTH) : 1;
   localparam int OPEN_SUM_W   = ADC_W + OPEN_CNT_W;
   localparam int LOADED_SUM_W = ADC_W + LOADED_CNT_W;
   localparam int CNT_W        = $clog2(RING_MAX + 1);
   localparam int SUM_W        = ADC_W + CNT_W;

   localparam logic [ADC_W-1:0]    ADC_MAX    = 12'd4095;
   localparam logic [OUT_MV_W-1:0] NO_SAMPLES = 16'hFFFF;

   // Sample kind codes
   localparam logic [1:0] KIND_OPEN   = 2'd1;
   localparam logic [1:0] KIND_LOADED = 2'd2;

   // Configuration port
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = PADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_VREF = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_EXT  = 1'b1;
   localparam logic [VREF_W-1:0]    VREF_RESET = 13'd4840;
   localparam logic [EXT_W-1:0]     EXT_RESET  = 16'd3250;

   // Discharge curve
   localparam int PCT_W        = 7;
   localparam int TABLE_POINTS = 8;
   localparam int SEG_W        = 3;
   localparam int LDIFF_W      = 9;
   localparam int LDC_W        = 6;
   localparam int LPROD_W      = LDIFF_W + LDC_W;
   localparam int LQ_W         = 6;
   localparam int LSTEP_W      = 3;

   localparam logic [MV_W-1:0] TABLE_MV [TABLE_POINTS] = '{
      13'd3200, 13'd2975, 13'd2900, 13'd2850, 13'd2800, 13'd2675, 13'd2525, 13'd2200
   };
   localparam logic [PCT_W-1:0] TABLE_PCT [TABLE_POINTS] = '{
      7'd100, 7'd99, 7'd98, 7'd95, 7'd80, 7'd40, 7'd20, 7'd0
   };

   // Sequencer states
   typedef enum logic [2:0] {
      TOP_IDLE,
      TOP_UPDATE,
      TOP_CONV,
      TOP_WAIT,
      TOP_LEVEL,
      TOP_LDIV,
      TOP_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_DIV_MEAN,
      CONV_MUL,
      CONV_DIV_SCALE
   } conv_state_type;

endpackage

@@ rtl/core/ble_ram.sv @@
// ----------------------------------------------------------------------------
// ble_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ble_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ble_conv.sv @@
// ----------------------------------------------------------------------------
// ble_conv
// Bit-serial conversion of a ring sum to millivolts: mean by division,
// scale by the reference, divide by full scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ble_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ble_pkg::SUM_W-1:0]     sum,
   input  logic [ble_pkg::CNT_W-1:0]     count,
   input  logic [ble_pkg::VREF_W-1:0]    vref,
   output logic                          busy,
   output logic [ble_pkg::OUT_MV_W-1:0]  mv
);
   import ble_pkg::*;

   conv_state_type        state_ff, state_in;
   logic [ADC_W-1:0]      rem_ff, rem_in;
   logic [MV_W-1:0]       sh_ff, sh_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [ADC_W-1:0]      divisor_ff, divisor_in;
   logic [OUT_MV_W-1:0]   mv_ff, mv_in;

   logic [ADC_W-1:0]      div_divisor;
   logic [ADC_W:0]        trial;
   logic                  take;
   logic [ADC_W-1:0]      rem_step;
   logic [MV_W-1:0]       sh_step;
   logic [VREF_W:0]       mul_sum;
   logic [PROD_W-1:0]     prod_step;
   logic                  last_adc_step;
   logic                  last_mv_step;

   // One restoring divide step and one shift-add multiply step
   always_comb begin
      div_divisor   = (state_ff == CONV_DIV_MEAN) ? divisor_ff : ADC_MAX;
      trial         = {rem_ff, sh_ff[MV_W-1]};
      take          = (trial >= {1'b0, div_divisor});
      rem_step      = take ? ADC_W'(trial - {1'b0, div_divisor}) : trial[ADC_W-1:0];
      sh_step       = {sh_ff[MV_W-2:0], take};
      mul_sum       = {1'b0, prod_ff[PROD_W-1:ADC_W]} + (prod_ff[0] ? {1'b0, vref} : '0);
      prod_step     = {mul_sum, prod_ff[ADC_W-1:1]};
      last_adc_step = (step_ff == STEP_W'(ADC_W - 1));
      last_mv_step  = (step_ff == STEP_W'(MV_W - 1));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (start && (count != '0)) begin
               state_in = CONV_DIV_MEAN;
            end
         end
         CONV_DIV_MEAN: begin
            if (last_adc_step) begin
               state_in = CONV_MUL;
            end
         end
         CONV_MUL: begin
            if (last_adc_step) begin
               state_in = CONV_DIV_SCALE;
            end
         end
         CONV_DIV_SCALE: begin
            if (last_mv_step) begin
               state_in = CONV_IDLE;
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
   end

   // Datapath per state
   always_comb begin
      rem_in     = rem_ff;
      sh_in      = sh_ff;
      prod_in    = prod_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      mv_in      = mv_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (start) begin
               if (count == '0) begin
                  mv_in = NO_SAMPLES;
               end else begin
                  // High sum bits seed the remainder, low bits shift in
                  rem_in                   = ADC_W'(sum[SUM_W-1:ADC_W]);
                  sh_in                    = '0;
                  sh_in[MV_W-1 -: ADC_W]   = sum[ADC_W-1:0];
                  divisor_in               = ADC_W'(count);
                  step_in                  = '0;
               end
            end
         end
         CONV_DIV_MEAN: begin
            rem_in  = rem_step;
            sh_in   = sh_step;
            step_in = step_ff + 1'b1;
            if (last_adc_step) begin
               prod_in = PROD_W'(sh_step[ADC_W-1:0]);
               step_in = '0;
            end
         end
         CONV_MUL: begin
            prod_in = prod_step;
            step_in = step_ff + 1'b1;
            if (last_adc_step) begin
               rem_in  = prod_step[PROD_W-1:MV_W];
               sh_in   = prod_step[MV_W-1:0];
               step_in = '0;
            end
         end
         CONV_DIV_SCALE: begin
            rem_in  = rem_step;
            sh_in   = sh_step;
            step_in = step_ff + 1'b1;
            if (last_mv_step) begin
               mv_in = OUT_MV_W'(sh_step);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff     <= rem_in;
      sh_ff      <= sh_in;
      prod_ff    <= prod_in;
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      mv_ff      <= mv_in;
   end

   assign busy = (state_ff != CONV_IDLE);
   assign mv   = mv_ff;

   `ASSERT_IMPLIES(a_mean_rem_bound, clock, reset, state_ff == CONV_DIV_MEAN, rem_ff < divisor_ff, "mean remainder not below count")
   `ASSERT_IMPLIES(a_scale_rem_bound, clock, reset, state_ff == CONV_DIV_SCALE, rem_ff < ADC_MAX, "scale remainder not below full scale")
   `ASSERT_NEXT(a_start_runs, clock, reset, state_ff == CONV_IDLE && start && count != '0, state_ff == CONV_DIV_MEAN, "start with samples did not begin the mean division")

endmodule

@@ rtl/core/battery_level_estimator_top.sv @@
// ----------------------------------------------------------------------------
// battery_level_estimator_top
// Ring averages of open-circuit and loaded ADC samples in millivolts, and a
// capacity level interpolated over the discharge curve.
// ----------------------------------------------------------------------------
// Channel  Ports                                    Dir     Handshake
// req      req_sample_kind, req_adc_sample          in      req_valid / req_ready
// rsp      rsp_open_mv, rsp_loaded_mv,              out     rsp_valid / rsp_ready
//          rsp_level_pct, rsp_level_valid
// csr      psel, penable, pwrite, paddr, pwdata,    in/out  APB, pready tied high
//          prdata, pready
//
// An item runs from acceptance to a registered result through bit-serial steps:
// 12 divide, 12 multiply and 13 divide per ring in ble_conv, rings in parallel,
// then 6 level divide steps when the level is interpolated; an empty ring skips
// its steps. The next item is accepted only once the result is registered.
// Synchronous reset clears counts, sums, pointers and sequencers and restores
// the register defaults. A stalled result waits while the next item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_level_estimator_top (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_sample_kind,
   input  logic [15:0]                    req_adc_sample,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ble_pkg::OUT_MV_W-1:0]   rsp_open_mv,
   output logic [ble_pkg::OUT_MV_W-1:0]   rsp_loaded_mv,
   output logic [ble_pkg::PCT_W-1:0]      rsp_level_pct,
   output logic                           rsp_level_valid,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ble_pkg::PADDR_W-1:0]    paddr,
   input  logic [ble_pkg::PDATA_W-1:0]    pwdata,
   output logic [ble_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready
);
   import ble_pkg::*;

   top_state_type             state_ff, state_in;

   logic [VREF_W-1:0]         vref_ff, vref_in;
   logic [EXT_W-1:0]          ext_ff, ext_in;

   logic [1:0]                kind_ff, kind_in;
   logic [ADC_W-1:0]          sample_ff, sample_in;

   logic [OPEN_CNT_W-1:0]     open_count_ff, open_count_in;
   logic [OPEN_PTR_W-1:0]     open_wpos_ff, open_wpos_in;
   logic [OPEN_SUM_W-1:0]     open_sum_ff, open_sum_in;
   logic [ADC_W-1:0]          open_rdata;
   logic                      open_push;
   logic                      open_full;

   logic [LOADED_CNT_W-1:0]   loaded_count_ff, loaded_count_in;
   logic [LOADED_PTR_W-1:0]   loaded_wpos_ff, loaded_wpos_in;
   logic [LOADED_SUM_W-1:0]   loaded_sum_ff, loaded_sum_in;
   logic [ADC_W-1:0]          loaded_rdata;
   logic                      loaded_push;
   logic                      loaded_full;

   logic                      conv_start;
   logic                      open_busy;
   logic                      loaded_busy;
   logic [OUT_MV_W-1:0]       open_mv;
   logic [OUT_MV_W-1:0]       loaded_mv;

   logic [SEG_W-1:0]          seg;
   logic [MV_W-1:0]           seg_vh;
   logic [MV_W-1:0]           seg_vl;
   logic [PCT_W-1:0]          seg_ch;
   logic [PCT_W-1:0]          seg_cl;
   logic [LDIFF_W-1:0]        ldiff;
   logic [LDC_W-1:0]          ldc;
   logic [LPROD_W-1:0]        lprod;
   logic [LDIFF_W-1:0]        ldvs;
   logic                      level_ok;
   logic                      top_clip;
   logic                      bot_clip;
   logic                      level_interp;

   logic [LDIFF_W-1:0]        lrem_ff, lrem_in;
   logic [LQ_W-1:0]           lsh_ff, lsh_in;
   logic [LSTEP_W-1:0]        lstep_ff, lstep_in;
   logic [LDIFF_W-1:0]        ldiv_ff, ldiv_in;
   logic [PCT_W-1:0]          lbase_ff, lbase_in;
   logic [PCT_W-1:0]          pct_ff, pct_in;
   logic                      lvalid_ff, lvalid_in;
   logic [LDIFF_W:0]          ltrial;
   logic                      ltake;
   logic [LDIFF_W-1:0]        lrem_step;
   logic [LQ_W-1:0]           lsh_step;
   logic                      last_lstep;

   logic                      out_free;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_MV_W-1:0]       rsp_open_mv_ff, rsp_open_mv_in;
   logic [OUT_MV_W-1:0]       rsp_loaded_mv_ff, rsp_loaded_mv_in;
   logic [PCT_W-1:0]          rsp_pct_ff, rsp_pct_in;
   logic                      rsp_lvalid_ff, rsp_lvalid_in;

   // Sample rings, read at the write pointer for the entry being replaced
   ble_ram #(.WIDTH(ADC_W), .DEPTH(OPEN_DEPTH)) u_open_ram (
      .clock   (clock),
      .wr_en   (open_push),
      .wr_addr (open_wpos_ff),
      .wr_data (sample_ff),
      .rd_addr (open_wpos_ff),
      .rd_data (open_rdata)
   );

   ble_ram #(.WIDTH(ADC_W), .DEPTH(LOADED_DEPTH)) u_loaded_ram (
      .clock   (clock),
      .wr_en   (loaded_push),
      .wr_addr (loaded_wpos_ff),
      .wr_data (sample_ff),
      .rd_addr (loaded_wpos_ff),
      .rd_data (loaded_rdata)
   );

   // Averaging units, one per ring, run side by side
   ble_conv u_open_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .sum   (SUM_W'(open_sum_ff)),
      .count (CNT_W'(open_count_ff)),
      .vref  (vref_ff),
      .busy  (open_busy),
      .mv    (open_mv)
   );

   ble_conv u_loaded_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .sum   (SUM_W'(loaded_sum_ff)),
      .count (CNT_W'(loaded_count_ff)),
      .vref  (vref_ff),
      .busy  (loaded_busy),
      .mv    (loaded_mv)
   );

   // Ring bookkeeping: replace the oldest entry in the running sum once full
   always_comb begin
      open_push   = (state_ff == TOP_UPDATE) && (kind_ff == KIND_OPEN);
      open_full   = (open_count_ff == OPEN_CNT_W'(OPEN_DEPTH));
      open_sum_in = open_sum_ff;
      open_wpos_in  = open_wpos_ff;
      open_count_in = open_count_ff;
      if (open_push) begin
         open_sum_in = open_sum_ff + OPEN_SUM_W'(sample_ff)
                       - OPEN_SUM_W'(open_full ? open_rdata : '0);
         open_wpos_in = (open_wpos_ff == OPEN_PTR_W'(OPEN_DEPTH - 1)) ? '0
                        : open_wpos_ff + 1'b1;
         if (!open_full) begin
            open_count_in = open_count_ff + 1'b1;
         end
      end

      loaded_push   = (state_ff == TOP_UPDATE) && (kind_ff == KIND_LOADED);
      loaded_full   = (loaded_count_ff == LOADED_CNT_W'(LOADED_DEPTH));
      loaded_sum_in = loaded_sum_ff;
      loaded_wpos_in  = loaded_wpos_ff;
      loaded_count_in = loaded_count_ff;
      if (loaded_push) begin
         loaded_sum_in = loaded_sum_ff + LOADED_SUM_W'(sample_ff)
                         - LOADED_SUM_W'(loaded_full ? loaded_rdata : '0);
         loaded_wpos_in = (loaded_wpos_ff == LOADED_PTR_W'(LOADED_DEPTH - 1)) ? '0
                          : loaded_wpos_ff + 1'b1;
         if (!loaded_full) begin
            loaded_count_in = loaded_count_ff + 1'b1;
         end
      end
   end

   // Curve segment lookup and level divider step
   always_comb begin
      level_ok = (loaded_count_ff != '0) && (loaded_mv <= ext_ff);
      top_clip = (loaded_mv >= OUT_MV_W'(TABLE_MV[0]));
      bot_clip = (loaded_mv <= OUT_MV_W'(TABLE_MV[TABLE_POINTS-1]));
      level_interp = level_ok && !top_clip && !bot_clip;

      // lowest segment whose lower point lies at or below the voltage
      seg = SEG_W'(TABLE_POINTS - 2);
      for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
         if (loaded_mv >= OUT_MV_W'(TABLE_MV[i+1])) begin
            seg = SEG_W'(i);
         end
      end
      seg_vh = TABLE_MV[seg];
      seg_vl = TABLE_MV[SEG_W'(seg + 1'b1)];
      seg_ch = TABLE_PCT[seg];
      seg_cl = TABLE_PCT[SEG_W'(seg + 1'b1)];
      ldiff  = LDIFF_W'(loaded_mv - OUT_MV_W'(seg_vl));
      ldc    = LDC_W'(seg_ch - seg_cl);
      lprod  = LPROD_W'(ldiff) * LPROD_W'(ldc);
      ldvs   = LDIFF_W'(seg_vh - seg_vl);

      ltrial     = {lrem_ff, lsh_ff[LQ_W-1]};
      ltake      = (ltrial >= {1'b0, ldiv_ff});
      lrem_step  = ltake ? LDIFF_W'(ltrial - {1'b0, ldiv_ff}) : ltrial[LDIFF_W-1:0];
      lsh_step   = {lsh_ff[LQ_W-2:0], ltake};
      last_lstep = (lstep_ff == LSTEP_W'(LQ_W - 1));

      out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (req_valid) begin
               state_in = TOP_UPDATE;
            end
         end
         TOP_UPDATE: begin
            state_in = TOP_CONV;
         end
         TOP_CONV: begin
            state_in = TOP_WAIT;
         end
         TOP_WAIT: begin
            if (!open_busy && !loaded_busy) begin
               state_in = TOP_LEVEL;
            end
         end
         TOP_LEVEL: begin
            state_in = level_interp ? TOP_LDIV : TOP_OUT;
         end
         TOP_LDIV: begin
            if (last_lstep) begin
               state_in = TOP_OUT;
            end
         end
         TOP_OUT: begin
            if (out_free) begin
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // Outputs and datapath per state
   always_comb begin
      req_ready        = 1'b0;
      conv_start       = 1'b0;
      kind_in          = kind_ff;
      sample_in        = sample_ff;
      lrem_in          = lrem_ff;
      lsh_in           = lsh_ff;
      lstep_in         = lstep_ff;
      ldiv_in          = ldiv_ff;
      lbase_in         = lbase_ff;
      pct_in           = pct_ff;
      lvalid_in        = lvalid_ff;
      rsp_open_mv_in   = rsp_open_mv_ff;
      rsp_loaded_mv_in = rsp_loaded_mv_ff;
      rsp_pct_in       = rsp_pct_ff;
      rsp_lvalid_in    = rsp_lvalid_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         TOP_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_sample_kind;
               sample_in = (req_adc_sample > 16'(ADC_MAX)) ? ADC_MAX
                           : req_adc_sample[ADC_W-1:0];
            end
         end
         TOP_CONV: begin
            conv_start = 1'b1;
         end
         TOP_LEVEL: begin
            lvalid_in = level_ok;
            if (!level_ok) begin
               pct_in = '0;
            end else if (top_clip) begin
               pct_in = TABLE_PCT[0];
            end else if (bot_clip) begin
               pct_in = TABLE_PCT[TABLE_POINTS-1];
            end else begin
               // quotient stays below 2^LQ_W, so the high bits seed the remainder
               lrem_in  = LDIFF_W'(lprod >> LQ_W);
               lsh_in   = lprod[LQ_W-1:0];
               ldiv_in  = ldvs;
               lbase_in = seg_cl;
               lstep_in = '0;
            end
         end
         TOP_LDIV: begin
            lrem_in  = lrem_step;
            lsh_in   = lsh_step;
            lstep_in = lstep_ff + 1'b1;
            if (last_lstep) begin
               pct_in = PCT_W'(lsh_step) + lbase_ff;
            end
         end
         TOP_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_open_mv_in   = open_mv;
               rsp_loaded_mv_in = loaded_mv;
               rsp_pct_in       = pct_ff;
               rsp_lvalid_in    = lvalid_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Register writes
   always_comb begin
      vref_in = vref_ff;
      ext_in  = ext_ff;
      if (psel && penable && pwrite) begin
         case (paddr[PADDR_W-1:2])
            REG_VREF: vref_in = pwdata[VREF_W-1:0];
            REG_EXT:  ext_in  = pwdata[EXT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (paddr[PADDR_W-1:2])
         REG_VREF: prdata = PDATA_W'(vref_ff);
         REG_EXT:  prdata = PDATA_W'(ext_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= TOP_IDLE;
         vref_ff         <= VREF_RESET;
         ext_ff          <= EXT_RESET;
         open_count_ff   <= '0;
         open_wpos_ff    <= '0;
         open_sum_ff     <= '0;
         loaded_count_ff <= '0;
         loaded_wpos_ff  <= '0;
         loaded_sum_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vref_ff         <= vref_in;
         ext_ff          <= ext_in;
         open_count_ff   <= open_count_in;
         open_wpos_ff    <= open_wpos_in;
         open_sum_ff     <= open_sum_in;
         loaded_count_ff <= loaded_count_in;
         loaded_wpos_ff  <= loaded_wpos_in;
         loaded_sum_ff   <= loaded_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      kind_ff          <= kind_in;
      sample_ff        <= sample_in;
      lrem_ff          <= lrem_in;
      lsh_ff           <= lsh_in;
      lstep_ff         <= lstep_in;
      ldiv_ff          <= ldiv_in;
      lbase_ff         <= lbase_in;
      pct_ff           <= pct_in;
      lvalid_ff        <= lvalid_in;
      rsp_open_mv_ff   <= rsp_open_mv_in;
      rsp_loaded_mv_ff <= rsp_loaded_mv_in;
      rsp_pct_ff       <= rsp_pct_in;
      rsp_lvalid_ff    <= rsp_lvalid_in;
   end

   assign pready          = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_open_mv     = rsp_open_mv_ff;
   assign rsp_loaded_mv   = rsp_loaded_mv_ff;
   assign rsp_level_pct   = rsp_pct_ff;
   assign rsp_level_valid = rsp_lvalid_ff;

   `ASSERT_IMPLIES(a_open_wpos_tracks_count, clock, reset, open_count_ff != OPEN_CNT_W'(OPEN_DEPTH), OPEN_CNT_W'(open_wpos_ff) == open_count_ff, "open write pointer out of step with count")
   `ASSERT_IMPLIES(a_loaded_count_bound, clock, reset, 1'b1, loaded_count_ff <= LOADED_CNT_W'(LOADED_DEPTH), "loaded count above ring depth")
   `ASSERT_IMPLIES(a_level_range, clock, reset, rsp_valid_ff, (rsp_lvalid_ff && rsp_pct_ff <= 7'd100) || (!rsp_lvalid_ff && rsp_pct_ff == '0), "level out of range for its valid flag")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_level_estimator_top. Items go in over the
// valid/ready request channel, and a local predictor keeps its own copy of
// both sample rings and of the two registers. Each result item is compared
// with the oldest predicted report. The registers are programmed and read
// back over APB between phases. A directed part covers empty rings, sample
// clamping and every segment of the discharge curve. Random traffic then runs
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ble_pkg::*;

   // Kind codes the package leaves unnamed
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam int SIDE_OPEN   = 0;
   localparam int SIDE_LOADED = 1;
   localparam int RING_SLOTS  = 32;
   localparam int ROUND_ITEMS = 50;
   localparam int SETTLE_CYCLES = 60;

   // Loaded voltages to land on: the external limit, table points and spans
   localparam int CURVE_POINTS = 18;
   localparam int CURVE_MV [CURVE_POINTS] = '{
      3251, 3250, 3200, 3199, 2975, 2940, 2900, 2851, 2850,
      2825, 2800, 2700, 2675, 2600, 2525, 2201, 2200, 0
   };

   typedef struct packed {
      logic [OUT_MV_W-1:0] open_mv;
      logic [OUT_MV_W-1:0] loaded_mv;
      logic [PCT_W-1:0]    level_pct;
      logic                level_valid;
   } battery_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_sample_kind = 2'd0;
   logic [15:0]           req_adc_sample = 16'd0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [OUT_MV_W-1:0]   rsp_open_mv;
   logic [OUT_MV_W-1:0]   rsp_loaded_mv;
   logic [PCT_W-1:0]      rsp_level_pct;
   logic                  rsp_level_valid;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PADDR_W-1:0]    paddr = '0;
   logic [PDATA_W-1:0]    pwdata = '0;
   logic [PDATA_W-1:0]    prdata;
   logic                  pready;

   // Predictor state
   logic [ADC_W-1:0]  ring_hist [2][RING_SLOTS];
   int                ring_fill [2];
   int                ring_wp [2];
   logic [VREF_W-1:0] vref_q;
   logic [EXT_W-1:0]  ext_q;

   battery_report_type reports_due [$];
   int mismatches = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int config_round = 0;
   int sample_center = 2048;

   battery_level_estimator_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_kind (req_sample_kind),
      .req_adc_sample  (req_adc_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_open_mv     (rsp_open_mv),
      .rsp_loaded_mv   (rsp_loaded_mv),
      .rsp_level_pct   (rsp_level_pct),
      .rsp_level_valid (rsp_level_valid),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   // Stall the result channel at the current phase's rate
   always @(posedge clock) begin
      rsp_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
   endtask

   // Mean of the filled slots, scaled to millivolts
   function automatic logic [OUT_MV_W-1:0] ring_average_mv(input int side);
      int n;
      int sum;
      n = ring_fill[side];
      sum = 0;
      if (n == 0)
         return NO_SAMPLES;
      for (int i = 0; i < n; i++)
         sum += int'(ring_hist[side][i]);
      return OUT_MV_W'(((sum / n) * int'(vref_q)) / int'(ADC_MAX));
   endfunction

   // Interpolate capacity over the discharge curve
   function automatic int discharge_pct(input int mv);
      int vh;
      int vl;
      int ch;
      int cl;
      if (mv >= int'(TABLE_MV[0]))
         return int'(TABLE_PCT[0]);
      if (mv <= int'(TABLE_MV[TABLE_POINTS-1]))
         return int'(TABLE_PCT[TABLE_POINTS-1]);
      for (int i = 0; i + 1 < TABLE_POINTS; i++) begin
         vh = int'(TABLE_MV[i]);
         vl = int'(TABLE_MV[i+1]);
         ch = int'(TABLE_PCT[i]);
         cl = int'(TABLE_PCT[i+1]);
         if (mv >= vl)
            return ((mv - vl) * (ch - cl)) / (vh - vl) + cl;
      end
      return 0;
   endfunction

   // Store one clamped sample and predict the report it causes
   task automatic predict_report(input logic [1:0] kind, input logic [15:0] adc);
      logic [ADC_W-1:0] clamped;
      int side;
      battery_report_type r;
      clamped = (adc > 16'(ADC_MAX)) ? ADC_MAX : adc[ADC_W-1:0];
      side = -1;
      if (kind == KIND_OPEN)
         side = SIDE_OPEN;
      else if (kind == KIND_LOADED)
         side = SIDE_LOADED;
      if (side >= 0) begin
         ring_hist[side][ring_wp[side]] = clamped;
         ring_wp[side] = (ring_wp[side] + 1) % RING_SLOTS;
         if (ring_fill[side] < RING_SLOTS)
            ring_fill[side]++;
      end
      r.open_mv = ring_average_mv(SIDE_OPEN);
      r.loaded_mv = ring_average_mv(SIDE_LOADED);
      r.level_pct = '0;
      r.level_valid = 1'b0;
      if (ring_fill[SIDE_LOADED] != 0 && r.loaded_mv <= ext_q) begin
         r.level_pct = PCT_W'(discharge_pct(int'(r.loaded_mv)));
         r.level_valid = 1'b1;
      end
      reports_due.push_back(r);
   endtask

   // Offer one item, hold it until accepted, then predict its report
   task automatic send_sample(input logic [1:0] kind, input logic [15:0] adc);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample_kind <= kind;
      req_adc_sample <= adc;
      do
         @(posedge clock);
      while (!req_ready);
      predict_report(kind, adc);
   endtask

   // Drop valid and wait until every predicted report has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (reports_due.size() != 0)
         @(posedge clock);
   endtask

   // Read one register and compare with the predicted value
   task automatic csr_read_check(input logic [REG_IDX_W-1:0] idx);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      if (idx == REG_VREF) begin
         if (prdata[VREF_W-1:0] !== vref_q)
            report_mismatch("vref_x4_mv readback", int'(prdata[VREF_W-1:0]), int'(vref_q));
      end else begin
         if (prdata[EXT_W-1:0] !== ext_q)
            report_mismatch("external_supply_mv readback", int'(prdata[EXT_W-1:0]),
                            int'(ext_q));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program one register once the block is idle, then read it back
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input int value);
      logic [PDATA_W-1:0] word;
      wait_idle();
      // junk above the register width must be ignored
      word = $urandom();
      if (idx == REG_VREF)
         word[VREF_W-1:0] = value[VREF_W-1:0];
      else
         word[EXT_W-1:0] = value[EXT_W-1:0];
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      if (idx == REG_VREF)
         vref_q = word[VREF_W-1:0];
      else
         ext_q = word[EXT_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      csr_read_check(idx);
   endtask

   // Compare each accepted result item with the oldest prediction
   always @(posedge clock) begin
      battery_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reports_due.size() == 0) begin
            report_mismatch("unexpected result, open_mv", int'(rsp_open_mv), -1);
         end else begin
            want = reports_due.pop_front();
            if (rsp_open_mv !== want.open_mv)
               report_mismatch("open_mv", int'(rsp_open_mv), int'(want.open_mv));
            if (rsp_loaded_mv !== want.loaded_mv)
               report_mismatch("loaded_mv", int'(rsp_loaded_mv), int'(want.loaded_mv));
            if (rsp_level_pct !== want.level_pct)
               report_mismatch("level_pct", int'(rsp_level_pct), int'(want.level_pct));
            if (rsp_level_valid !== want.level_valid)
               report_mismatch("level_valid", int'(rsp_level_valid), int'(want.level_valid));
         end
      end
   end

   task automatic test_reset_values();
      csr_read_check(REG_VREF);
      csr_read_check(REG_EXT);
   endtask

   // Both rings empty: dropped kinds leave every average at the no-sample code
   task automatic test_empty_rings();
      send_sample(KIND_NONE, 16'h0000);
      send_sample(KIND_NONE, 16'hFFFF);
      send_sample(KIND_SPARE, 16'hAAAA);
      send_sample(KIND_SPARE, 16'h5555);
   endtask

   // Open samples above full scale clamp to the top code
   task automatic test_sample_clamp();
      send_sample(KIND_OPEN, 16'hFFFF);
      send_sample(KIND_OPEN, 16'd4096);
      send_sample(KIND_OPEN, 16'd0);
   endtask

   // With a full-scale loaded mean, loaded_mv equals vref; walk the curve with it
   task automatic test_discharge_curve();
      send_sample(KIND_LOADED, 16'hFFFF);
      csr_write(REG_EXT, 3250);
      for (int i = 0; i < CURVE_POINTS; i++) begin
         csr_write(REG_VREF, CURVE_MV[i]);
         send_sample(KIND_NONE, 16'($urandom()));
      end
   endtask

   // Pick the register setting for one round of random items
   task automatic program_round();
      case (config_round % 6)
         0: begin
            csr_write(REG_VREF, 8191);
            csr_write(REG_EXT, 65535);
         end
         1: begin
            csr_write(REG_VREF, 0);
            csr_write(REG_EXT, 0);
         end
         2: begin
            csr_write(REG_VREF, int'(VREF_RESET));
            csr_write(REG_EXT, int'(EXT_RESET));
         end
         default: begin
            csr_write(REG_VREF, $urandom_range(4500, 8191));
            csr_write(REG_EXT, $urandom_range(2000, 3600));
         end
      endcase
      config_round++;
      sample_center = $urandom_range(900, 2700);
   endtask

   // Mostly drifting sensor readings, with extremes and out-of-range noise
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      logic [1:0] kind;
      logic [15:0] adc;
      int pick;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i % ROUND_ITEMS == 0)
            program_round();
         pick = $urandom_range(99);
         if (pick < 45)
            kind = KIND_OPEN;
         else if (pick < 90)
            kind = KIND_LOADED;
         else if (pick < 95)
            kind = KIND_NONE;
         else
            kind = KIND_SPARE;
         sample_center += $urandom_range(0, 40) - 20;
         if (sample_center < 0)
            sample_center = 0;
         if (sample_center > int'(ADC_MAX))
            sample_center = int'(ADC_MAX);
         pick = $urandom_range(99);
         if (pick < 70)
            adc = 16'(sample_center + $urandom_range(0, 96) - 48);
         else if (pick < 78)
            adc = (pick < 74) ? 16'd0 : 16'(ADC_MAX);
         else if (pick < 88)
            adc = 16'($urandom_range(4096, 65535));
         else
            adc = 16'($urandom_range(0, int'(ADC_MAX)));
         // keep the drift from wrapping below zero
         if (pick < 70 && adc > 16'd8191)
            adc = 16'd0;
         send_sample(kind, adc);
      end
   endtask

   initial begin
      int waited;
      ring_fill[SIDE_OPEN] = 0;
      ring_fill[SIDE_LOADED] = 0;
      ring_wp[SIDE_OPEN] = 0;
      ring_wp[SIDE_LOADED] = 0;
      vref_q = VREF_RESET;
      ext_q = EXT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_empty_rings();
      test_sample_clamp();
      test_discharge_curve();
      test_random_traffic(250, 0, 0);
      test_random_traffic(250, 82, 0);
      test_random_traffic(250, 0, 82);
      test_random_traffic(250, 8, 8);

      // Drain outstanding reports, then watch for stray results
      req_valid <= 1'b0;
      waited = 0;
      while (reports_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (reports_due.size() != 0)
         report_mismatch("reports never returned", 0, reports_due.size());
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ble_pkg.sv
rtl/core/ble_ram.sv
rtl/core/ble_conv.sv
rtl/core/battery_level_estimator_top.sv
sim/tb.sv
